FILE: rtl/ovn2d_pkg.sv
// shared types, constants and the prime table of the octave value noise block
// no dependencies; imported by the controller, the datapath and the top level
package ovn2d_pkg;

    localparam int DEF_MAX_OCTAVES = 8;
    localparam int PRIME_COUNT     = 36;
    localparam int PIDX_W          = 6;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED        = 2'd0,
        CFG_OCTAVES     = 2'd1,
        CFG_START_FREQ  = 2'd2,
        CFG_PERSISTENCE = 2'd3
    } t_cfg_idx;

    localparam logic [15:0] RST_SEED        = 16'd0;
    localparam logic [3:0]  RST_OCTAVES     = 4'd4;
    localparam logic [23:0] RST_START_FREQ  = 24'd65536;
    localparam logic [16:0] RST_PERSISTENCE = 17'd32768;
    localparam logic [16:0] UNITY_Q16       = 17'd65536;

    // seed / 36 as multiply by reciprocal, exact for 16-bit seeds
    localparam logic [15:0] MOD_RECIP = 16'd58255;
    localparam int          MOD_SHIFT = 21;

    // commands from controller to datapath, one per step
    typedef struct packed {
        logic load;
        logic modr;
        logic scale;
        logic mul1;
        logic mul2;
        logic mul3;
        logic weight;
        logic accum;
        logic finish;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic no_octaves;
        logic last_octave;
    } t_status;

    function automatic logic [31:0] prime_rom(input logic [PIDX_W-1:0] idx);
        logic [31:0] p;
        case (idx)
            6'd0:  p = 32'd10007;
            6'd1:  p = 32'd17839;
            6'd2:  p = 32'd20533;
            6'd3:  p = 32'd22093;
            6'd4:  p = 32'd22271;
            6'd5:  p = 32'd44257;
            6'd6:  p = 32'd55633;
            6'd7:  p = 32'd66931;
            6'd8:  p = 32'd84179;
            6'd9:  p = 32'd101723;
            6'd10: p = 32'd113723;
            6'd11: p = 32'd131707;
            6'd12: p = 32'd149867;
            6'd13: p = 32'd174617;
            6'd14: p = 32'd199399;
            6'd15: p = 32'd230653;
            6'd16: p = 32'd256181;
            6'd17: p = 32'd275461;
            6'd18: p = 32'd294979;
            6'd19: p = 32'd320627;
            6'd20: p = 32'd340127;
            6'd21: p = 32'd359581;
            6'd22: p = 32'd379649;
            6'd23: p = 32'd406183;
            6'd24: p = 32'd425989;
            6'd25: p = 32'd506101;
            6'd26: p = 32'd649007;
            6'd27: p = 32'd704023;
            6'd28: p = 32'd759557;
            6'd29: p = 32'd780163;
            6'd30: p = 32'd800693;
            6'd31: p = 32'd828601;
            6'd32: p = 32'd856789;
            6'd33: p = 32'd884497;
            6'd34: p = 32'd990851;
            6'd35: p = 32'd999931;
            default: p = 32'd10007;
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/ovn2d_ctrl.sv
// sequencer of the octave value noise block: one step of the datapath per state
// depends on ovn2d_pkg for the command and status structs
module ovn2d_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ovn2d_pkg::t_status i_status,
    output ovn2d_pkg::t_cmd   o_cmd,
    output logic              o_busy
);
    import ovn2d_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MODR   = 9'b000000010,
        ST_SCALE  = 9'b000000100,
        ST_MUL1   = 9'b000001000,
        ST_MUL2   = 9'b000010000,
        ST_MUL3   = 9'b000100000,
        ST_WEIGHT = 9'b001000000,
        ST_ACCUM  = 9'b010000000,
        ST_FINISH = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MODR;
                end
            end
            ST_MODR: begin
                o_cmd.modr = 1'b1;
                n_state    = i_status.no_octaves ? ST_FINISH : ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = ST_MUL3;
            end
            ST_MUL3: begin
                o_cmd.mul3 = 1'b1;
                n_state    = ST_WEIGHT;
            end
            ST_WEIGHT: begin
                o_cmd.weight = 1'b1;
                n_state      = ST_ACCUM;
            end
            ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = i_status.last_octave ? ST_FINISH : ST_SCALE;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

FILE: rtl/ovn2d_dpath.sv
// datapath of the octave value noise block: config registers, coordinate scale,
// hash multiplies, amplitude weighting and accumulation; depends on ovn2d_pkg
module ovn2d_dpath #(
    parameter int MAX_OCTAVES = ovn2d_pkg::DEF_MAX_OCTAVES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ovn2d_pkg::t_cmd                    i_cmd,
    output ovn2d_pkg::t_status                 o_status,
    input  logic                               i_cfg_we,
    input  logic [ovn2d_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ovn2d_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic signed [15:0]                 i_coord_x,
    input  logic signed [15:0]                 i_coord_y,
    output logic                               o_valid,
    output logic signed [23:0]                 o_noise_value
);
    import ovn2d_pkg::*;

    localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
    localparam int ACC_W = 48 + $clog2(MAX_OCTAVES + 1);
    localparam logic [ACC_W-1:0] ONE_Q46 = {{(ACC_W-47){1'b0}}, 1'b1, 46'd0};

    // configuration registers
    logic [15:0] r_seed;
    logic [3:0]  r_oct_cnt;
    logic [23:0] r_start_freq;
    logic [16:0] r_persist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed       <= RST_SEED;
            r_oct_cnt    <= RST_OCTAVES;
            r_start_freq <= RST_START_FREQ;
            r_persist    <= RST_PERSISTENCE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SEED:        r_seed       <= i_cfg_data[15:0];
                CFG_OCTAVES:     r_oct_cnt    <= i_cfg_data[3:0];
                CFG_START_FREQ:  r_start_freq <= i_cfg_data;
                CFG_PERSISTENCE: r_persist    <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // clamped octave count and persistence
    logic [OCT_W-1:0] octs;
    logic [16:0]      pers_eff;

    always_comb begin
        if (int'(r_oct_cnt) > MAX_OCTAVES) begin
            octs = OCT_W'(MAX_OCTAVES);
        end else begin
            octs = OCT_W'(r_oct_cnt);
        end
        pers_eff = (r_persist > UNITY_Q16) ? UNITY_Q16 : r_persist;
    end

    // working registers
    logic [39:0]              r_px;
    logic [39:0]              r_py;
    logic                     r_negx;
    logic                     r_negy;
    logic [10:0]              r_q;
    logic [PIDX_W-1:0]        r_pidx;
    logic [OCT_W-1:0]         r_oct;
    logic [31:0]              r_n;
    logic [31:0]              r_t;
    logic [16:0]              r_amp;
    logic signed [47:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [23:0]       r_out;
    logic                     r_valid;

    function automatic logic [PIDX_W-1:0] pidx_add(input logic [PIDX_W-1:0] idx,
                                                   input logic [1:0] inc);
        logic [PIDX_W:0] s;
        s = {1'b0, idx} + (PIDX_W + 1)'(inc);
        if (s >= (PIDX_W + 1)'(PRIME_COUNT)) begin
            s = s - (PIDX_W + 1)'(PRIME_COUNT);
        end
        return s[PIDX_W-1:0];
    endfunction

    // magnitudes of the coordinates, -32768 maps to 32768
    logic [15:0] mag_x;
    logic [15:0] mag_y;
    assign mag_x = i_coord_x[15] ? (16'd0 - $unsigned(i_coord_x)) : $unsigned(i_coord_x);
    assign mag_y = i_coord_y[15] ? (16'd0 - $unsigned(i_coord_y)) : $unsigned(i_coord_y);

    // seed mod 36 from the reciprocal quotient, one correction step
    logic [15:0] q36;
    logic [15:0] rem;
    assign q36 = 16'(r_q) * 16'(PRIME_COUNT);
    assign rem = r_seed - q36;

    // scaled coordinates for the current octave and the shift-xor hash input
    logic [47:0] sh_x;
    logic [47:0] sh_y;
    logic [31:0] qx;
    logic [31:0] qy;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] n0;

    always_comb begin
        sh_x = 48'(r_px) << r_oct;
        sh_y = 48'(r_py) << r_oct;
        qx   = sh_x[47:16];
        qy   = sh_y[47:16];
        sx   = r_negx ? (32'd0 - qx) : qx;
        sy   = r_negy ? (32'd0 - qy) : qy;
        n0   = sx + sy * 32'd57 + 32'(r_seed);
    end

    logic [PIDX_W-1:0] idx1;
    logic [PIDX_W-1:0] idx2;
    assign idx1 = pidx_add(r_pidx, 2'd1);
    assign idx2 = pidx_add(r_pidx, 2'd2);

    // per-octave noise value 2^30 - k31, signed
    logic signed [31:0] v;
    assign v = 32'sd1073741824 - $signed({1'b0, r_t[30:0]});

    logic [33:0]             amp_prod;
    logic signed [ACC_W-1:0] t_round;
    assign amp_prod = 34'(r_amp) * 34'(pers_eff);
    assign t_round  = r_acc + $signed(ONE_Q46);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px   <= 40'(mag_x) * 40'(r_start_freq);
            r_py   <= 40'(mag_y) * 40'(r_start_freq);
            r_negx <= i_coord_x[15];
            r_negy <= i_coord_y[15];
            r_q    <= 11'((32'(r_seed) * 32'(MOD_RECIP)) >> MOD_SHIFT);
            r_oct  <= '0;
            r_amp  <= UNITY_Q16;
            r_acc  <= '0;
        end
        if (i_cmd.modr) begin
            r_pidx <= (rem >= 16'(PRIME_COUNT)) ? PIDX_W'(rem - 16'(PRIME_COUNT))
                                                : PIDX_W'(rem);
        end
        if (i_cmd.scale) begin
            r_n <= n0 ^ (n0 << 13);
        end
        if (i_cmd.mul1) begin
            r_t <= r_n * r_n;
        end
        if (i_cmd.mul2) begin
            r_t <= r_t * prime_rom(r_pidx) + prime_rom(idx1);
        end
        if (i_cmd.mul3) begin
            r_t <= r_n * r_t + prime_rom(idx2);
        end
        if (i_cmd.weight) begin
            r_prod <= 48'(v) * 48'($signed({1'b0, r_amp}));
            r_amp  <= 17'(amp_prod >> 16);
        end
        if (i_cmd.accum) begin
            r_acc  <= r_acc + ACC_W'(r_prod);
            r_oct  <= r_oct + 1'b1;
            r_pidx <= pidx_add(r_pidx, 2'd3);
        end
        if (i_cmd.finish) begin
            // arithmetic shift floors toward minus infinity
            r_out <= 24'(t_round >>> 31);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    assign o_status.no_octaves  = (octs == '0);
    assign o_status.last_octave = (r_oct == octs - 1'b1);
    assign o_valid              = r_valid;
    assign o_noise_value        = r_out;

endmodule

FILE: rtl/octave_value_noise_2d_top.sv
// top level of the 2d octave value noise block
// depends on ovn2d_pkg, ovn2d_ctrl and ovn2d_dpath
//
// A request is taken when i_start is high while o_busy is low; it carries one
// signed 16-bit coordinate pair. o_busy then stays high while one step
// reduces the seed to a prime table index, each of N octaves takes six steps
// (scale and shift-xor, three dependent 32-bit hash multiplies through one
// multiplier path, amplitude weighting, accumulation), where N is the octave
// count register clamped to MAX_OCTAVES, and a last step rounds the sum.
// The result appears on o_noise_value with o_valid high for exactly
// one cycle, in the same cycle o_busy drops; the receiver cannot hold it off
// and must take it then. A new request may be issued in that very cycle.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
// once and belong in the idle time between requests.
module octave_value_noise_2d_top #(
    parameter int MAX_OCTAVES = ovn2d_pkg::DEF_MAX_OCTAVES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request side
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [15:0]                 i_coord_x,
    input  logic signed [15:0]                 i_coord_y,
    // result side
    output logic                               o_valid,
    output logic signed [23:0]                 o_noise_value,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [ovn2d_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ovn2d_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ovn2d_pkg::*;

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    // sequencer: one state per datapath step, loops over the octaves
    ovn2d_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    // datapath: holds the config registers and the shared hash unit
    ovn2d_dpath #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .o_valid       (o_valid),
        .o_noise_value (o_noise_value)
    );

endmodule

FILE: rtl/ovn2d_chk.sv
// port-level checks of the octave value noise top level, bound to it
// depends on ovn2d_pkg and octave_value_noise_2d_top
module ovn2d_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_start,
    input logic                              o_busy,
    input logic                              o_valid,
    input logic                              i_cfg_we,
    input logic [ovn2d_pkg::CFG_IDX_W-1:0]   i_cfg_index
);
    import ovn2d_pkg::*;

    // a taken request always starts work
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request taken but block not busy");

    // a result only arrives as the block goes idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_busy && $past(o_busy)))
        else $error("result strobe outside end of work");

    // work never ends without a result
    a_end_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(o_busy)) |-> o_valid)
        else $error("work ended without a result");

    // one strobe per request
    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // registers are written only between requests, with a known index
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> (!o_busy && !i_start && !$isunknown(i_cfg_index)))
        else $error("configuration write while a request is in flight");

endmodule

bind octave_value_noise_2d_top ovn2d_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_valid     (o_valid),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index)
);

FILE: verif/octave_value_noise_2d_top_tb.sv
// self-checking testbench for octave_value_noise_2d_top: directed and random coordinate
// requests over several register settings, each result checked against a local predictor
// depends on ovn2d_pkg and the rtl of octave_value_noise_2d_top
module octave_value_noise_2d_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ovn2d_pkg::*;

    localparam int          MAX_OCT = DEF_MAX_OCTAVES;
    localparam int          N_PHASE = 10;
    localparam int          PER_PHASE = 100;
    // long enough for the longest request, at MAX_OCT octaves, plus margin
    localparam int          SETTLE = 6 * MAX_OCT + 12;

    // prime triples of the hash, picked by (seed + 3*octave + k) mod 36
    localparam logic [31:0] PRIMES [PRIME_COUNT] = '{
        32'd10007,  32'd17839,  32'd20533,  32'd22093,  32'd22271,  32'd44257,
        32'd55633,  32'd66931,  32'd84179,  32'd101723, 32'd113723, 32'd131707,
        32'd149867, 32'd174617, 32'd199399, 32'd230653, 32'd256181, 32'd275461,
        32'd294979, 32'd320627, 32'd340127, 32'd359581, 32'd379649, 32'd406183,
        32'd425989, 32'd506101, 32'd649007, 32'd704023, 32'd759557, 32'd780163,
        32'd800693, 32'd828601, 32'd856789, 32'd884497, 32'd990851, 32'd999931
    };

    // what the driver does next: issue a request, write a register, or wait for idle
    typedef enum logic [1:0] {
        ACT_SAMPLE,
        ACT_WRITE,
        ACT_DRAIN
    } t_act;

    typedef struct {
        t_act                   act;
        logic [15:0]            x;
        logic [15:0]            y;
        t_cfg_idx               idx;
        logic [CFG_DATA_W-1:0]  data;
        int                     gap;
    } t_action;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_start = 1'b0;
    logic signed [15:0]         i_coord_x = '0;
    logic signed [15:0]         i_coord_y = '0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       o_busy;
    logic                       o_valid;
    logic signed [23:0]         o_noise_value;

    // register copies as the block should hold them
    logic [15:0]                seed_sh = RST_SEED;
    logic [3:0]                 oct_sh = RST_OCTAVES;
    logic [23:0]                freq_sh = RST_START_FREQ;
    logic [16:0]                pers_sh = RST_PERSISTENCE;

    t_action                    todo_q[$];
    logic signed [23:0]         noise_q[$];
    int                         n_taken = 0;    // requests accepted
    int                         n_done = 0;     // results that matched an expectation slot
    int                         n_err = 0;
    int                         gap_left = -1;  // idle cycles still owed before the next request

    octave_value_noise_2d_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .o_valid       (o_valid),
        .o_noise_value (o_noise_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // coordinate times frequency, magnitude truncated toward zero, then wrapped to 32 bits
    function automatic logic [31:0] scaled(input logic [15:0] raw, input logic [63:0] freq);
        logic [63:0] mag;
        logic [63:0] q;
        mag = raw[15] ? 64'd65536 - {48'd0, raw} : {48'd0, raw};
        q = (mag * freq) >> 16;
        return raw[15] ? -q[31:0] : q[31:0];
    endfunction

    // expected noise value for one coordinate pair under the current register copies
    function automatic logic signed [23:0] noise_at(input logic [15:0] cx,
                                                    input logic [15:0] cy);
        logic [3:0]         octs;
        logic [16:0]        pers;
        logic [63:0]        freq;
        logic [63:0]        amp;
        logic [31:0]        n;
        logic [31:0]        h;
        logic [31:0]        p0;
        logic [31:0]        p1;
        logic [31:0]        p2;
        logic signed [63:0] acc;
        logic signed [63:0] v;
        // octave count and persistence saturate
        octs = (oct_sh > MAX_OCT) ? 4'(MAX_OCT) : oct_sh;
        pers = (pers_sh > UNITY_Q16) ? UNITY_Q16 : pers_sh;
        amp = 64'd65536;
        acc = '0;
        for (int i = 0; i < octs; i++) begin
            freq = {40'd0, freq_sh} << i;
            n = scaled(cx, freq) + 32'd57 * scaled(cy, freq) + {16'd0, seed_sh};
            p0 = PRIMES[(32'(seed_sh) + 32'(3 * i)) % PRIME_COUNT];
            p1 = PRIMES[(32'(seed_sh) + 32'(3 * i + 1)) % PRIME_COUNT];
            p2 = PRIMES[(32'(seed_sh) + 32'(3 * i + 2)) % PRIME_COUNT];
            n = (n << 13) ^ n;
            h = (n * (n * n * p0 + p1) + p2) & 32'h7fffffff;
            v = 64'sd1073741824 - $signed({32'd0, h});
            acc = acc + v * $signed(amp);
            amp = (amp * pers) >> 16;
        end
        // (sum + 1) / 2 in q.16, floor toward minus infinity
        acc = acc + (64'sd1 << 46);
        return 24'(acc >>> 31);
    endfunction

    task automatic add_sample(input logic [15:0] x, input logic [15:0] y, input int gap);
        t_action a;
        a.act = ACT_SAMPLE;
        a.x = x;
        a.y = y;
        a.idx = CFG_SEED;
        a.data = '0;
        a.gap = gap;
        todo_q.push_back(a);
    endtask

    task automatic add_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        t_action a;
        a.act = ACT_WRITE;
        a.x = '0;
        a.y = '0;
        a.idx = idx;
        a.data = data;
        a.gap = 0;
        todo_q.push_back(a);
    endtask

    task automatic add_drain();
        t_action a;
        a.act = ACT_DRAIN;
        a.x = '0;
        a.y = '0;
        a.idx = CFG_SEED;
        a.data = '0;
        a.gap = 0;
        todo_q.push_back(a);
    endtask

    // driver: works through todo_q, one action per clock at most
    always @(posedge i_clk) begin
        logic nxt_start;
        logic nxt_we;
        int   took;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_cfg_we <= 1'b0;
            gap_left = -1;
        end else begin
            nxt_start = i_start;
            nxt_we = 1'b0;
            took = 0;
            // request taken at this edge: predict from the coordinates still on the ports
            if (i_start && !o_busy) begin
                noise_q.push_back(noise_at(i_coord_x, i_coord_y));
                took = 1;
                nxt_start = 1'b0;
            end
            // start is only raised again in this same step, never lowered and raised
            if (!nxt_start && todo_q.size() != 0) begin
                case (todo_q[0].act)
                    ACT_SAMPLE: begin
                        if (gap_left < 0)
                            gap_left = todo_q[0].gap;
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            i_coord_x <= todo_q[0].x;
                            i_coord_y <= todo_q[0].y;
                            nxt_start = 1'b1;
                            gap_left = -1;
                            void'(todo_q.pop_front());
                        end
                    end
                    ACT_WRITE: begin
                        // registers change only with no request outstanding
                        if (n_taken + took == n_done) begin
                            i_cfg_index <= todo_q[0].idx;
                            i_cfg_data <= todo_q[0].data;
                            nxt_we = 1'b1;
                            case (todo_q[0].idx)
                                CFG_SEED:        seed_sh = todo_q[0].data[15:0];
                                CFG_OCTAVES:     oct_sh = todo_q[0].data[3:0];
                                CFG_START_FREQ:  freq_sh = todo_q[0].data[23:0];
                                CFG_PERSISTENCE: pers_sh = todo_q[0].data[16:0];
                                default: ;
                            endcase
                            void'(todo_q.pop_front());
                        end
                    end
                    default: begin
                        // sender holds off until every result is back
                        if (n_taken + took == n_done)
                            void'(todo_q.pop_front());
                    end
                endcase
            end
            i_start <= nxt_start;
            i_cfg_we <= nxt_we;
            n_taken <= n_taken + took;
        end
    end

    // monitor: results cannot be held off, so each strobe is taken as it comes
    always @(posedge i_clk) begin
        logic signed [23:0] want;
        if (i_rst_n && o_valid) begin
            if (n_taken == n_done) begin
                $display("%0t: noise_value expected none actual %0d", $time, o_noise_value);
                n_err++;
            end else begin
                want = noise_q.pop_front();
                if (o_noise_value !== want) begin
                    $display("%0t: noise_value expected %0d actual %0d",
                             $time, want, o_noise_value);
                    n_err++;
                end
                n_done <= n_done + 1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [15:0] cx;
        logic [15:0] cy;
        int          burst;
        int          kind;
        logic [23:0] f;

        // directed: reset settings, coordinate extremes
        add_sample(16'h0000, 16'h0000, 0);
        add_sample(16'h7fff, 16'h7fff, 0);
        add_sample(16'h8000, 16'h8000, 3);
        add_sample(16'h7fff, 16'h8000, 0);
        add_sample(16'h8000, 16'h7fff, 1);
        add_sample(16'h0001, 16'hffff, 0);
        add_sample(16'hffff, 16'h0001, 0);
        // zero octaves gives exactly one half
        add_write(CFG_OCTAVES, 24'd0);
        add_sample(16'h1234, 16'hedcb, 0);
        add_sample(16'h8000, 16'h7fff, 2);
        // octave count above the maximum, widest frequency so coordinates wrap,
        // persistence above one with junk above its width, top seed
        add_write(CFG_OCTAVES, 24'hfffff);
        add_write(CFG_START_FREQ, 24'hffffff);
        add_write(CFG_PERSISTENCE, 24'hffffff);
        add_write(CFG_SEED, 24'hffffff);
        add_sample(16'h7fff, 16'h7fff, 0);
        add_sample(16'h8000, 16'h8000, 0);
        add_sample(16'h5555, 16'haaaa, 0);
        add_sample(16'haaaa, 16'h5555, 0);
        // zero frequency, zero persistence, seed that wraps the prime index
        add_write(CFG_OCTAVES, 24'd8);
        add_write(CFG_START_FREQ, 24'd0);
        add_write(CFG_PERSISTENCE, 24'd0);
        add_write(CFG_SEED, 24'd35);
        add_sample(16'h7fff, 16'h8000, 0);
        add_sample(16'h0000, 16'h0000, 5);
        // persistence of exactly one, single octave, fractional frequency
        add_write(CFG_OCTAVES, 24'd1);
        add_write(CFG_PERSISTENCE, 24'd65536);
        add_write(CFG_START_FREQ, 24'h008000);
        add_sample(16'hffff, 16'h0003, 0);
        add_sample(16'h8000, 16'h7fff, 0);
        add_drain();

        // random phases: new settings each time, some phases back to back
        for (int p = 0; p < N_PHASE; p++) begin
            burst = (p % 3 == 0);
            if (p == 0)
                add_write(CFG_OCTAVES, 24'd8);
            else if (p == 1)
                add_write(CFG_OCTAVES, 24'd0);
            else
                add_write(CFG_OCTAVES, 24'($urandom_range(0, 15)));
            kind = $urandom_range(0, 3);
            case (kind)
                0: f = 24'($urandom());
                1: f = 24'($urandom_range(0, 24'h20000));
                2: f = 24'($urandom_range(0, 255)) << 16;
                default: f = (p == 2) ? 24'd0 : 24'hffffff;
            endcase
            add_write(CFG_START_FREQ, f);
            add_write(CFG_PERSISTENCE, (p == 3) ? 24'd65536 : 24'($urandom()));
            add_write(CFG_SEED, (p == 4) ? 24'd0 : 24'($urandom()));
            for (int k = 0; k < PER_PHASE; k++) begin
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    cx = 16'($urandom());
                    cy = 16'($urandom());
                end else if (kind < 9) begin
                    cx = 16'($signed($urandom_range(0, 8)) - 4);
                    cy = 16'($signed($urandom_range(0, 8)) - 4);
                end else begin
                    cx = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                    cy = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                end
                add_sample(cx, cy, burst ? 0 : $urandom_range(0, 12));
                // occasional full pause until every result has come back
                if ($urandom_range(0, 39) == 0)
                    add_drain();
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample at the falling edge so every update of the rising edge has settled
        do
            @(negedge i_clk);
        while (todo_q.size() != 0 || i_start || n_taken != n_done);
        repeat (SETTLE) @(negedge i_clk);
        if (n_err == 0 && noise_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
